### hw/rtl/csvfs_pkg.sv
package csvfs_pkg;

  // fixed byte codes
  localparam logic [7:0] NL_BYTE         = 8'd10;
  localparam logic [7:0] DELIM_RESET     = 8'd44;
  localparam logic [7:0] QUOTE_RESET     = 8'd34;

  // input item kinds
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_EOC  = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_DELIMITER = 2'd0;
  localparam logic [1:0] CFG_QUOTE     = 2'd1;
  localparam logic [1:0] CFG_HEADER_EN = 2'd2;

  // parser state carried between bytes
  typedef struct packed {
    logic in_quoted;
    logic quote_pending;
    logic line_has_bytes;
    logic first_line;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    in_quoted:      1'b0,
    quote_pending:  1'b0,
    line_has_bytes: 1'b0,
    first_line:     1'b1
  };

  // one result item
  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic       field_end;
    logic       row_end;
    logic       header_row;
  } result_t;

  // active configuration
  typedef struct packed {
    logic [7:0] delimiter_char;
    logic [7:0] quote_char;
    logic       header_enable;
  } csv_cfg_t;

endpackage

### hw/rtl/csvfs_step.sv
module csvfs_step (
  input  logic                    func,
  input  logic [7:0]              text_byte,
  input  csvfs_pkg::csv_cfg_t     cfg,
  input  csvfs_pkg::parse_state_t state,
  output csvfs_pkg::parse_state_t state_nxt,
  output logic                    emit,
  output csvfs_pkg::result_t      result
);

  logic is_quote;
  logic is_delim;
  logic hdr;
  logic quoted_eff;

  assign is_quote = (text_byte == cfg.quote_char);
  assign is_delim = (text_byte == cfg.delimiter_char);
  assign hdr      = cfg.header_enable & state.first_line;

  // a pending quote followed by a non-quote closes quoted mode
  assign quoted_eff = state.quote_pending ? 1'b0 : state.in_quoted;

  // one byte of parsing
  always_comb begin
    state_nxt = state;
    emit      = 1'b0;
    result    = '0;
    result.header_row = hdr;
    if (func == csvfs_pkg::FUNC_EOC) begin
      // flush an unfinished row and restart
      emit             = state.line_has_bytes;
      result.field_end = 1'b1;
      result.row_end   = 1'b1;
      state_nxt        = csvfs_pkg::STATE_RESET;
    end else if (text_byte == csvfs_pkg::NL_BYTE) begin
      // newline always ends the physical line
      emit                     = state.line_has_bytes;
      result.field_end         = 1'b1;
      result.row_end           = 1'b1;
      state_nxt                = csvfs_pkg::STATE_RESET;
      state_nxt.first_line     = 1'b0;
    end else begin
      state_nxt.line_has_bytes = 1'b1;
      state_nxt.quote_pending  = 1'b0;
      if (state.quote_pending && is_quote) begin
        // doubled quote gives one literal quote
        emit              = 1'b1;
        result.data_valid = 1'b1;
        result.data_byte  = text_byte;
      end else if (is_quote) begin
        state_nxt.in_quoted     = 1'b1;
        state_nxt.quote_pending = quoted_eff;
      end else if (is_delim && !quoted_eff) begin
        state_nxt.in_quoted = quoted_eff;
        emit                = 1'b1;
        result.field_end    = 1'b1;
      end else begin
        state_nxt.in_quoted = quoted_eff;
        emit                = 1'b1;
        result.data_valid   = 1'b1;
        result.data_byte    = text_byte;
      end
    end
  end

endmodule

### hw/rtl/csv_field_splitter_core.sv
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_stall  | in_func, in_text_byte
// out     | out | out_valid/out_stall| data_valid, data_byte, field_end, row_end, header_row
// cfg     | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
// one transaction per cycle while in_stall is low; each byte is parsed in the cycle it is taken
// a result appears in the output register in the cycle after its input transaction
// in_stall rises only while the output register is full and out_stall holds it
// rst_n (synchronous) restores delimiter 44, quote 34, header off, first line set
// cfg_ready is always high
module csv_field_splitter_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_func,
  input  logic [7:0] in_text_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_data_valid,
  output logic [7:0] out_data_byte,
  output logic       out_field_end,
  output logic       out_row_end,
  output logic       out_header_row,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  csvfs_pkg::csv_cfg_t     cfg_r;
  csvfs_pkg::parse_state_t state_r;
  csvfs_pkg::parse_state_t state_nxt;
  csvfs_pkg::result_t      res_r;
  csvfs_pkg::result_t      res_nxt;
  logic                    out_valid_r;
  logic                    emit;
  logic                    in_acc;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delimiter_char <= csvfs_pkg::DELIM_RESET;
      cfg_r.quote_char     <= csvfs_pkg::QUOTE_RESET;
      cfg_r.header_enable  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        csvfs_pkg::CFG_DELIMITER: cfg_r.delimiter_char <= cfg_data;
        csvfs_pkg::CFG_QUOTE:     cfg_r.quote_char     <= cfg_data;
        csvfs_pkg::CFG_HEADER_EN: cfg_r.header_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // per-byte parse step
  csvfs_step u_step (
    .func      (in_func),
    .text_byte (in_text_byte),
    .cfg       (cfg_r),
    .state     (state_r),
    .state_nxt (state_nxt),
    .emit      (emit),
    .result    (res_nxt)
  );

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= csvfs_pkg::STATE_RESET;
    end else if (in_acc) begin
      state_r <= state_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= emit;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data_valid = res_r.data_valid;
  assign out_data_byte  = res_r.data_byte;
  assign out_field_end  = res_r.field_end;
  assign out_row_end    = res_r.row_end;
  assign out_header_row = res_r.header_row;

  // row end comes only with field end
  a_row_has_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!res_r.row_end || res_r.field_end))
    else $error("row_end without field_end");

  // data and field end never share a transaction
  a_data_xor_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.data_valid && res_r.field_end))
    else $error("data byte and field end together");

  // header flag only when enabled
  a_header_en: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.header_row) |-> cfg_r.header_enable)
    else $error("header flagged while disabled");

  // end of content restarts the parser
  a_eoc_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_func == csvfs_pkg::FUNC_EOC) |=>
      (state_r.first_line && !state_r.in_quoted && !state_r.line_has_bytes))
    else $error("parser not restarted after end of content");

  // a stalled result is never overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !in_acc)
    else $error("input taken while result stalled");

endmodule

### verif/tb_top.sv
module tb_top;

  // split predictor plus queue of results still owed by the block
  class split_checker;
    csvfs_pkg::result_t      pending_results[$];
    csvfs_pkg::csv_cfg_t     regs;
    csvfs_pkg::parse_state_t st;
    int                      errors;
    int                      checked;

    function new();
      regs = '{delimiter_char: csvfs_pkg::DELIM_RESET,
               quote_char:     csvfs_pkg::QUOTE_RESET,
               header_enable:  1'b0};
      st = csvfs_pkg::STATE_RESET;
      errors = 0;
      checked = 0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // append one prediction to the owed queue
    function void add_expected(csvfs_pkg::result_t r);
      pending_results = {pending_results, r};
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] d);
      case (idx)
        csvfs_pkg::CFG_DELIMITER: regs.delimiter_char = d;
        csvfs_pkg::CFG_QUOTE:     regs.quote_char = d;
        csvfs_pkg::CFG_HEADER_EN: regs.header_enable = d[0];
        default: ;
      endcase
    endfunction

    // predict the result (if any) of one accepted input transaction
    function void note_input(logic f, logic [7:0] b);
      csvfs_pkg::result_t r;
      r = '0;
      r.header_row = regs.header_enable & st.first_line;

      // end of content flushes an open row and restarts
      if (f == csvfs_pkg::FUNC_EOC) begin
        if (st.line_has_bytes) begin
          r.field_end = 1'b1;
          r.row_end = 1'b1;
          add_expected(r);
        end
        st = csvfs_pkg::STATE_RESET;
        return;
      end

      // newline always ends the physical line
      if (b == csvfs_pkg::NL_BYTE) begin
        if (st.line_has_bytes) begin
          r.field_end = 1'b1;
          r.row_end = 1'b1;
          add_expected(r);
        end
        st.in_quoted = 1'b0;
        st.quote_pending = 1'b0;
        st.line_has_bytes = 1'b0;
        st.first_line = 1'b0;
        return;
      end

      st.line_has_bytes = 1'b1;

      // a held quote is resolved by this byte
      if (st.quote_pending) begin
        st.quote_pending = 1'b0;
        if (b == regs.quote_char) begin
          r.data_valid = 1'b1;
          r.data_byte = b;
          add_expected(r);
          return;
        end
        st.in_quoted = 1'b0;
      end

      if (b == regs.quote_char) begin
        if (st.in_quoted) st.quote_pending = 1'b1;
        else st.in_quoted = 1'b1;
        return;
      end

      if (b == regs.delimiter_char && !st.in_quoted) begin
        r.field_end = 1'b1;
        add_expected(r);
        return;
      end

      r.data_valid = 1'b1;
      r.data_byte = b;
      add_expected(r);
    endfunction

    // compare one accepted result with the oldest prediction
    task check_result(csvfs_pkg::result_t got);
      csvfs_pkg::result_t exp;
      if (pending_results.size() == 0) begin
        report($sformatf("result with nothing expected: %p", got));
        return;
      end
      exp = pending_results.pop_front();
      checked++;
      if (got.data_valid !== exp.data_valid)
        report($sformatf("data_valid got %b exp %b", got.data_valid, exp.data_valid));
      if (got.data_byte !== exp.data_byte)
        report($sformatf("data_byte got %h exp %h", got.data_byte, exp.data_byte));
      if (got.field_end !== exp.field_end)
        report($sformatf("field_end got %b exp %b", got.field_end, exp.field_end));
      if (got.row_end !== exp.row_end)
        report($sformatf("row_end got %b exp %b", got.row_end, exp.row_end));
      if (got.header_row !== exp.header_row)
        report($sformatf("header_row got %b exp %b", got.header_row, exp.header_row));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_func = 1'b0;
  logic [7:0] in_text_byte = 8'd0;
  logic       out_stall = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [1:0] cfg_index = 2'd0;
  logic [7:0] cfg_data = 8'd0;
  logic       in_stall;
  logic       out_valid;
  logic       out_data_valid;
  logic [7:0] out_data_byte;
  logic       out_field_end;
  logic       out_row_end;
  logic       out_header_row;
  logic       cfg_ready;

  split_checker chk;
  int  items_sent = 0;
  int  settings = 0;
  bit  idle_in = 1'b1;
  bit  idle_out = 1'b1;
  bit  hold_req = 1'b0;

  always #1 clk = ~clk;

  csv_field_splitter_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_text_byte   (in_text_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data_valid (out_data_valid),
    .out_data_byte  (out_data_byte),
    .out_field_end  (out_field_end),
    .out_row_end    (out_row_end),
    .out_header_row (out_header_row),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // offer one input transaction and wait until it is taken
  task send_item(logic f, logic [7:0] b);
    int gap;
    gap = idle_in ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_text_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chk.note_input(f, b);
    items_sent++;
  endtask

  task send_byte(logic [7:0] b);
    send_item(csvfs_pkg::FUNC_BYTE, b);
  endtask

  task send_eoc();
    send_item(csvfs_pkg::FUNC_EOC, 8'($urandom_range(0, 255)));
  endtask

  task write_cfg(logic [1:0] idx, logic [7:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    chk.set_reg(idx, d);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering, let every owed result drain, then cover the pipeline
  task settle();
    in_valid <= 1'b0;
    while (chk.pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // one mostly well-formed row with random content, some noise mixed in
  task send_row();
    int nf;
    int len;
    int r;
    bit quoted;
    logic [7:0] dl;
    logic [7:0] qt;
    dl = chk.regs.delimiter_char;
    qt = chk.regs.quote_char;
    if ($urandom_range(0, 7) == 0)
      send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    nf = $urandom_range(1, 4);
    for (int f = 0; f < nf; f++) begin
      quoted = ($urandom_range(0, 2) == 0);
      if (quoted) send_byte(qt);
      len = $urandom_range(0, 4);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 9);
        case (r)
          0: send_byte(8'($urandom_range(0, 255)));
          1: send_byte(dl);
          2: begin
            send_byte(qt);
            if (quoted) send_byte(qt);
          end
          3: send_byte(8'd13);
          default: send_byte(8'($urandom_range(32, 126)));
        endcase
      end
      if (quoted) send_byte(qt);
      if (f != nf - 1) send_byte(dl);
    end
    // row terminator, sometimes end of content, missing or followed by an empty line
    r = $urandom_range(0, 9);
    case (r)
      0: send_eoc();
      1: ;
      2: begin
        send_byte(csvfs_pkg::NL_BYTE);
        send_byte(csvfs_pkg::NL_BYTE);
      end
      default: send_byte(csvfs_pkg::NL_BYTE);
    endcase
  endtask

  // register settings per phase, extremes and collisions among them
  task configure(int p);
    logic [7:0] dl;
    logic [7:0] qt;
    logic       he;
    case (p)
      0: begin dl = 8'd44;  qt = 8'd34;  he = 1'b1; end
      1: begin dl = 8'd0;   qt = 8'd255; he = 1'b0; end
      2: begin dl = 8'd255; qt = 8'd0;   he = 1'b1; end
      3: begin dl = 8'd59;  qt = 8'd59;  he = 1'b1; end
      4: begin dl = 8'd9;   qt = csvfs_pkg::NL_BYTE; he = 1'b0; end
      5: begin dl = csvfs_pkg::NL_BYTE; qt = 8'd39; he = 1'b1; end
      6: begin dl = csvfs_pkg::DELIM_RESET; qt = csvfs_pkg::QUOTE_RESET; he = 1'b0; end
      default: begin
        dl = 8'($urandom_range(0, 255));
        qt = 8'($urandom_range(0, 255));
        he = 1'($urandom_range(0, 1));
      end
    endcase
    write_cfg(csvfs_pkg::CFG_DELIMITER, dl);
    write_cfg(csvfs_pkg::CFG_QUOTE, qt);
    write_cfg(csvfs_pkg::CFG_HEADER_EN, {7'd0, he});
    settings++;
  endtask

  // result side: random stalls, one long hold when asked
  initial begin
    int n;
    csvfs_pkg::result_t got;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        n = 48;
        hold_req = 1'b0;
      end else begin
        n = idle_out ? $urandom_range(0, 5) : 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got = '{out_data_valid, out_data_byte, out_field_end, out_row_end, out_header_row};
      chk.check_result(got);
    end
  end

  // main sequence
  initial begin
    int target;
    int guard;
    chk = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // plain fields, byte extremes and carriage return
    send_byte("a"); send_byte(","); send_byte("b"); send_byte(csvfs_pkg::NL_BYTE);
    send_byte(8'h00); send_byte(8'hff); send_byte(8'd13); send_byte(csvfs_pkg::NL_BYTE);
    // doubled quote, then pending quote closed by delimiter
    send_byte("\""); send_byte("x"); send_byte("\""); send_byte("\"");
    send_byte("y"); send_byte("\""); send_byte(","); send_byte(csvfs_pkg::NL_BYTE);
    // newline inside quotes, then an empty line
    send_byte("\""); send_byte("q"); send_byte(csvfs_pkg::NL_BYTE);
    send_byte(csvfs_pkg::NL_BYTE);
    // pending quote at end of content, then end of content on an empty line
    send_byte("\""); send_byte("z"); send_byte("\""); send_eoc();
    send_eoc();

    for (int p = 0; p < 8; p++) begin
      settle();
      configure(p);
      // restart so the header line is seen, sometimes as an empty line
      send_eoc();
      if ($urandom_range(0, 3) == 0) send_byte(csvfs_pkg::NL_BYTE);
      if (p == 1) begin
        // long receiver hold while the sender keeps pushing
        hold_req = 1'b1;
        idle_in = 1'b0;
        repeat (4) send_row();
      end
      target = items_sent + 70;
      while (items_sent < target) begin
        if (p == 2) begin
          idle_in = 1'b0;
          idle_out = 1'b0;
        end else begin
          idle_in = ($urandom_range(0, 3) != 0);
          idle_out = ($urandom_range(0, 3) != 0);
        end
        send_row();
        if (p == 4 && items_sent >= target - 40 && items_sent < target - 30) begin
          in_valid <= 1'b0;
          while (chk.pending_results.size() != 0) @(posedge clk);
          @(posedge clk);
        end
      end
    end

    // drain and let the pipeline empty
    in_valid <= 1'b0;
    guard = 0;
    while (chk.pending_results.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (5) @(posedge clk);
    if (chk.pending_results.size() != 0)
      chk.report($sformatf("%0d results never arrived", chk.pending_results.size()));

    $display("summary: %0d input transactions under %0d register settings, %0d results checked",
             items_sent, settings + 1, chk.checked);
    $display("summary: quoting, doubled quotes, empty lines, header rows and flushes exercised");
    if (chk.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

### csv_field_splitter_core.f
hw/rtl/csvfs_pkg.sv
hw/rtl/csvfs_step.sv
hw/rtl/csv_field_splitter_core.sv
verif/tb_top.sv
